### rtl/afuf_pkg.sv
// ----------------------------------------------------------------------------
// afuf_pkg - shared types and constants
// Widths, function codes and the divider request/response structs.
// ----------------------------------------------------------------------------
package afuf_pkg;

  localparam int unsigned FifoDepth  = 1024;
  localparam int unsigned MaxRequest = 64;
  localparam int unsigned IdxW       = $clog2(FifoDepth);
  localparam int unsigned LvlW       = $clog2(FifoDepth + 1);
  localparam int unsigned ReqW       = 7;
  localparam int unsigned SmpW       = 16;
  // dividend magnitude: 17-bit sample sum times an 11-bit gain
  localparam int unsigned DvdW       = 28;
  // divisor up to 2 * FifoDepth
  localparam int unsigned DvsW       = LvlW + 1;

  localparam logic [1:0] FuncPush = 2'd0;
  localparam logic [1:0] FuncPull = 2'd1;
  localparam logic [1:0] FuncWipe = 2'd2;
  localparam logic [1:0] FuncFade = 2'd3;

  typedef struct packed {
    logic                   start;
    logic                   neg;
    logic [DvdW-1:0]        dividend;
    logic [DvsW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic                   busy;
    logic signed [SmpW-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/afuf_div.sv
// ----------------------------------------------------------------------------
// afuf_div - shared restoring divider
// Unsigned magnitude divide, one quotient bit a cycle, sign applied at end.
// ----------------------------------------------------------------------------
module afuf_div import afuf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW:0]   rem_q, rem_d;
  logic [DvsW-1:0] dvs_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, done_q;
  logic [DvsW:0]   trial;

  always_comb begin
    trial = {rem_q[DvsW-1:0], quo_q[DvdW-1]};
    rem_d = trial;
    quo_d = {quo_q[DvdW-2:0], 1'b0};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d    = trial - {1'b0, dvs_q};
      quo_d[0] = 1'b1;
    end
    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_q[SmpW-1:0]) : $signed(quo_q[SmpW-1:0]);

endmodule

### rtl/audio_fifo_underrun_fade.sv
// ----------------------------------------------------------------------------
// audio_fifo_underrun_fade - stereo sample fifo with underrun fade-out
// Q1.15 pair store, pull as stereo or mono, underrun ramp, fade and wipe.
// ----------------------------------------------------------------------------
// push: pushes can follow back to back; plain pull: each result item is read
// and emitted in turn; underrun pull: each stored sample goes through the
// shared divider, both channels in stereo, the sum once in mono, and items past
// the fill level are sent as silence; fade: each stored pair is scaled, then
// every free entry is zeroed; wipe zeroes all 1024 entries; output stalls wait
// after reset a clearing pass zeroes the store, ready low
module audio_fifo_underrun_fade import afuf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic signed [SmpW-1:0] left_in_i,
  input  logic signed [SmpW-1:0] right_in_i,
  input  logic [ReqW-1:0]        request_count_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [SmpW-1:0] left_out_o,
  output logic signed [SmpW-1:0] right_out_o,
  output logic                   last_o,
  output logic [ReqW-1:0]        delivered_o
);

  typedef enum logic [3:0] {
    StClear, StIdle, StPullRd, StPullWt, StPullCalc, StDivL, StDivR,
    StEmit, StFadeRd, StFadeWt, StFadeDivL, StFadeDivR, StFadeWr, StFadeZero
  } state_e;

  state_e state_q;
  logic   mono_q;

  // sample store, registered read
  logic [31:0]     mem [FifoDepth];
  logic [31:0]     rd_q;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0]     wdata;

  logic [IdxW-1:0] rptr_q, wptr_q, cur_q;
  logic [LvlW-1:0] fill_q, cnt_q, j_q;
  logic [ReqW-1:0] n_q, k_q, dlv_q;
  logic            under_q;
  logic signed [SmpW-1:0] l_q, r_q, ol_q, or_q;
  logic signed [SmpW:0]   sum_q;

  div_req_t dreq;
  div_rsp_t drsp;

  afuf_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    return (32'(i) + 1 >= FifoDepth) ? '0 : i + IdxW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mono_q <= 1'b0;
    else if (cfg_we_i) mono_q <= cfg_wdata_i;
  end

  // divider operand: magnitude of sample or sum times gain
  logic signed [SmpW:0]   dsrc;
  logic [LvlW-1:0]        gain;
  logic [SmpW:0]          dmag;
  logic [DvsW-1:0]        dvs;
  logic                   div_go_q;
  always_comb begin
    dsrc   = (state_q == StDivL && mono_q) ? sum_q
           : ((state_q == StDivL || state_q == StFadeDivL) ? 17'(l_q) : 17'(r_q));
    dmag   = dsrc[SmpW] ? 17'(-dsrc) : 17'(dsrc);
    gain   = (state_q == StFadeDivL || state_q == StFadeDivR) ? cnt_q - j_q - LvlW'(1)
                                                              : cnt_q - LvlW'(k_q);
    dvs    = (state_q == StDivL && mono_q) ? {cnt_q, 1'b0} : DvsW'(cnt_q);
    dreq.start    = div_go_q;
    dreq.neg      = dsrc[SmpW];
    dreq.dividend = DvdW'(dmag) * DvdW'(gain);
    dreq.divisor  = dvs;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = '0;
    raddr = cur_q;
    case (state_q)
      StClear, StFadeZero: we = 1'b1;
      StIdle: begin
        raddr = rptr_q;
        if (in_valid_i && func_i == FuncPush && fill_q != LvlW'(FifoDepth)) begin
          we    = 1'b1;
          waddr = wptr_q;
          wdata = {right_in_i, left_in_i};
        end
      end
      StFadeWr: begin
        we    = 1'b1;
        wdata = {r_q, l_q};
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign left_out_o  = ol_q;
  assign right_out_o = or_q;
  assign last_o      = (k_q == n_q);
  assign delivered_o = (k_q == n_q) ? dlv_q : '0;

  logic [ReqW-1:0] nreq;
  assign nreq = (request_count_i > ReqW'(MaxRequest)) ? ReqW'(MaxRequest) : request_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      rptr_q   <= '0;
      wptr_q   <= '0;
      fill_q   <= '0;
      cur_q    <= '0;
      div_go_q <= 1'b0;
      k_q      <= '0;
      n_q      <= '0;
    end else begin
      div_go_q <= 1'b0;
      case (state_q)
        // zero every entry, then go idle
        StClear: begin
          cur_q <= nxt(cur_q);
          if (32'(cur_q) == FifoDepth - 1) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) begin
            case (func_i)
              FuncPush: if (fill_q != LvlW'(FifoDepth)) begin
                wptr_q <= nxt(wptr_q);
                fill_q <= fill_q + LvlW'(1);
              end
              FuncWipe: begin
                rptr_q <= '0; wptr_q <= '0; fill_q <= '0; cur_q <= '0;
                state_q <= StClear;
              end
              FuncFade: if (fill_q != '0) begin
                cnt_q <= fill_q; j_q <= '0; cur_q <= rptr_q;
                state_q <= StFadeRd;
              end
              FuncPull: if (request_count_i != '0) begin
                n_q     <= nreq;
                k_q     <= ReqW'(1);
                under_q <= fill_q < LvlW'(nreq);
                cnt_q   <= fill_q;
                dlv_q   <= (fill_q < LvlW'(nreq)) ? ReqW'(fill_q) : nreq;
                cur_q   <= rptr_q;
                state_q <= StPullRd;
              end
              default: ;
            endcase
          end
        end
        // k_q counts result items from 1
        StPullRd: state_q <= StPullWt;
        StPullWt: begin
          if (under_q && LvlW'(k_q) > cnt_q) begin
            ol_q <= '0; or_q <= '0;
            state_q <= StEmit;
          end else begin
            l_q   <= $signed(rd_q[15:0]);
            r_q   <= $signed(rd_q[31:16]);
            sum_q <= 17'($signed(rd_q[15:0])) + 17'($signed(rd_q[31:16]));
            rptr_q <= nxt(rptr_q);
            cur_q  <= nxt(rptr_q);
            fill_q <= fill_q - LvlW'(1);
            state_q <= StPullCalc;
          end
        end
        StPullCalc: begin
          if (!under_q) begin
            ol_q <= mono_q ? 16'(sum_q >>> 1) + 16'(sum_q[SmpW] & sum_q[0]) : l_q;
            or_q <= mono_q ? '0 : r_q;
            state_q <= StEmit;
          end else begin
            k_q <= k_q - ReqW'(1);
            div_go_q <= 1'b1;
            state_q <= StDivL;
          end
        end
        StDivL: begin
          if (drsp.done) begin
            ol_q <= drsp.quotient;
            if (mono_q) begin
              or_q <= '0; k_q <= k_q + ReqW'(1); state_q <= StEmit;
            end else begin
              div_go_q <= 1'b1; state_q <= StDivR;
            end
          end
        end
        StDivR: begin
          if (drsp.done) begin
            or_q <= drsp.quotient; k_q <= k_q + ReqW'(1); state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_ready_i) begin
            if (k_q == n_q) state_q <= StIdle;
            else begin
              k_q <= k_q + ReqW'(1);
              state_q <= StPullRd;
            end
          end
        end
        StFadeRd: state_q <= StFadeWt;
        StFadeWt: begin
          l_q <= $signed(rd_q[15:0]);
          r_q <= $signed(rd_q[31:16]);
          div_go_q <= 1'b1;
          state_q <= StFadeDivL;
        end
        StFadeDivL: if (drsp.done) begin
          l_q <= drsp.quotient; div_go_q <= 1'b1; state_q <= StFadeDivR;
        end
        StFadeDivR: if (drsp.done) begin
          r_q <= drsp.quotient; state_q <= StFadeWr;
        end
        StFadeWr: begin
          cur_q <= nxt(cur_q);
          j_q   <= j_q + LvlW'(1);
          if (j_q + LvlW'(1) == cnt_q) begin
            state_q <= (cnt_q == LvlW'(FifoDepth)) ? StIdle : StFadeZero;
          end else state_q <= StFadeRd;
        end
        // free entries sit between the write pointer and the read pointer
        StFadeZero: begin
          cur_q <= nxt(cur_q);
          if (nxt(cur_q) == rptr_q) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // a divide result only arrives in a state that waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == StDivL || state_q == StDivR ||
                   state_q == StFadeDivL || state_q == StFadeDivR))
    else $error("divider result in wrong state");

  // fill never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LvlW'(FifoDepth)) else $error("fill level overflow");

  // a push into a full store changes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i == FuncPush && fill_q == LvlW'(FifoDepth))
    |=> $stable(wptr_q)) else $error("push into full store moved pointer");

endmodule
